FILE: hdl/shamd_pkg.sv
`timescale 1ns / 1ps

package shamd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned COUNT_W = 61;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        BSEL_INPUT,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       shift_en;
        byte_sel_t  byte_sel;
        logic [2:0] len_idx;
        logic       count_inc;
        logic       load_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       restart;
        logic [2:0] word_idx;
    } shamd_cmd_t;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int unsigned s);
        ror = (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic logic [WORD_W-1:0] big0(input logic [WORD_W-1:0] v);
        big0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big1(input logic [WORD_W-1:0] v);
        big1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    function automatic logic [WORD_W-1:0] sig0(input logic [WORD_W-1:0] v);
        sig0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] sig1(input logic [WORD_W-1:0] v);
        sig1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

endpackage

FILE: hdl/shamd_ctrl.sv
`timescale 1ns / 1ps

module shamd_ctrl
    import shamd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       has_byte,
    input  logic       end_of_message,
    input  logic       out_ready,
    output logic       in_ready,
    output logic       out_valid,
    output shamd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       marker_reg, marker_next;
    logic       len_ok_reg, len_ok_next;
    logic       end_pend_reg, end_pend_next;
    logic       final_reg, final_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        round_next    = round_reg;
        word_next     = word_reg;
        marker_next   = marker_reg;
        len_ok_next   = len_ok_reg;
        end_pend_next = end_pend_reg;
        final_next    = final_reg;

        cmd           = '0;
        cmd.byte_sel  = BSEL_INPUT;
        cmd.round_idx = round_reg;
        cmd.word_idx  = word_reg;
        cmd.len_idx   = fill_reg[2:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        cmd.shift_en  = 1'b1;
                        cmd.count_inc = 1'b1;
                        fill_next     = fill_reg + 6'd1;
                    end
                    if (has_byte && (fill_reg == FILL_LAST))
                    begin
                        // block full: compress, remember a pending end mark
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        end_pend_next = end_of_message;
                        final_next    = 1'b0;
                        marker_next   = 1'b0;
                        state_next    = S_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        marker_next = 1'b0;
                        state_next  = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                cmd.shift_en = 1'b1;
                fill_next    = fill_reg + 6'd1;
                if (!marker_reg)
                begin
                    cmd.byte_sel = BSEL_MARK;
                    marker_next  = 1'b1;
                    len_ok_next  = (fill_reg < LEN_POS);
                end
                else if (len_ok_reg && (fill_reg >= LEN_POS))
                begin
                    cmd.byte_sel = BSEL_LEN;
                end
                else
                begin
                    cmd.byte_sel = BSEL_ZERO;
                end
                if (fill_reg == FILL_LAST)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    end_pend_next = 1'b1;
                    final_next    = marker_reg && len_ok_reg;
                    state_next    = S_ROUND;
                end
            end

            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                priority if (final_reg)
                begin
                    word_next  = '0;
                    state_next = S_EMIT;
                end
                else if (end_pend_reg)
                begin
                    // end pending: marker first if not yet placed, then zeros and length
                    len_ok_next = marker_reg;
                    state_next  = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_ready)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == WORD_LAST)
                    begin
                        cmd.restart   = 1'b1;
                        fill_next     = '0;
                        marker_next   = 1'b0;
                        len_ok_next   = 1'b0;
                        end_pend_next = 1'b0;
                        final_next    = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            round_reg    <= '0;
            word_reg     <= '0;
            marker_reg   <= 1'b0;
            len_ok_reg   <= 1'b0;
            end_pend_reg <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            round_reg    <= round_next;
            word_reg     <= word_next;
            marker_reg   <= marker_next;
            len_ok_reg   <= len_ok_next;
            end_pend_reg <= end_pend_next;
            final_reg    <= final_next;
        end
    end

endmodule

FILE: hdl/shamd_datapath.sv
`timescale 1ns / 1ps

module shamd_datapath
    import shamd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  shamd_cmd_t        cmd,
    input  logic [7:0]        data_byte,
    output logic [WORD_W-1:0] digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);

    logic [BLOCK_W-1:0] win_reg, win_next;
    logic [WORD_W-1:0]  chain_reg [8];
    logic [COUNT_W-1:0] count_reg;
    logic [WORD_W-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;

    logic [63:0]        len_bits;
    logic [5:0]         len_lsb;
    logic [7:0]         len_byte;
    logic [7:0]         byte_in;
    logic [WORD_W-1:0]  w0, w1, w9, w14, w_new;
    logic [WORD_W-1:0]  ch, maj, t1, t2;

    // bit length, big endian, one byte picked per padding beat
    assign len_bits = {count_reg, 3'b000};
    assign len_lsb  = {~cmd.len_idx, 3'b000};
    assign len_byte = len_bits[len_lsb +: 8];

    // schedule window: word j sits at the top j-th slot
    assign w0  = win_reg[511:480];
    assign w1  = win_reg[479:448];
    assign w9  = win_reg[223:192];
    assign w14 = win_reg[63:32];

    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_INPUT: byte_in = data_byte;
            BSEL_MARK:  byte_in = PAD_MARK;
            BSEL_ZERO:  byte_in = 8'h00;
            BSEL_LEN:   byte_in = len_byte;
            default:    byte_in = 8'h00;
        endcase

        w_new = sig1(w14) + w9 + sig0(w1) + w0;
        ch    = (e_reg & f_reg) ^ (~e_reg & g_reg);
        maj   = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t1    = h_reg + big1(e_reg) + ch + ROUND_K[cmd.round_idx] + w0;
        t2    = big0(a_reg) + maj;

        priority if (cmd.shift_en)
        begin
            win_next = {win_reg[BLOCK_W-9:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            win_next = {win_reg[BLOCK_W-WORD_W-1:0], w_new};
        end
        else
        begin
            win_next = win_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
            f_reg <= chain_reg[5];
            g_reg <= chain_reg[6];
            h_reg <= chain_reg[7];
        end
        else if (cmd.round_en)
        begin
            h_reg <= g_reg;
            g_reg <= f_reg;
            f_reg <= e_reg;
            e_reg <= d_reg + t1;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= a_reg;
            a_reg <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_HASH;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                chain_reg <= INIT_HASH;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.chain_add)
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    chain_reg[5] <= chain_reg[5] + f_reg;
                    chain_reg[6] <= chain_reg[6] + g_reg;
                    chain_reg[7] <= chain_reg[7] + h_reg;
                end
                if (cmd.count_inc)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
        end
    end

    assign digest_word = chain_reg[cmd.word_idx];
    assign word_index  = cmd.word_idx;
    assign last_word   = (cmd.word_idx == WORD_LAST);

endmodule

FILE: hdl/sha256_message_digest_unit.sv
`timescale 1ns / 1ps

// sha-256 over a byte stream. each input beat carries at most one message byte
// (has_byte) and may close the message (end_of_message); a beat with neither
// does nothing. while gathering, one byte is taken per cycle. when the 64th byte
// of a block arrives, input stalls for the 64 rounds through the single round
// unit, one round per cycle, and for the fold of the working variables into the
// chain value. at the end mark the block shifts in the 0x80 marker, zero fill
// and the 64-bit big-endian bit length one byte per cycle, which takes one
// compression, or two when fewer than nine bytes of the block were left. the
// digest then leaves as eight 32-bit output beats, h0 first, with word_index
// 0..7 and last_word on the eighth; input is held off until the last beat is
// taken, after which the unit starts a new message from the initial hash
// values. the byte count wraps modulo 2^61.
module sha256_message_digest_unit
    import shamd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    shamd_cmd_t cmd;

    // sequencer: fill count, padding steps, round counter, digest beats
    shamd_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_ready      (out_ready),
        .in_ready       (in_ready),
        .out_valid      (out_valid),
        .cmd            (cmd)
    );

    // block window / message schedule, round unit, chain value, byte count
    shamd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // input and output sides never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open at once");

    // a digest always begins with h0
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 3'd0))
        else $error("digest does not start at word 0");

    // digest words go out in order without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=>
            (out_valid && (word_index == 3'($past(word_index) + 3'd1))))
        else $error("digest beat out of order");

    // after the last word the unit takes input again
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> (in_ready && !out_valid))
        else $error("no restart after last digest beat");

endmodule
